// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the admission queue.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, kept on through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pdaq_pkg.sv =====
// Types and codes for the per-device admission queue.
// No dependencies.
`timescale 1ns / 1ps

package pdaq_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_MISS,
		ST_EXEC,
		ST_WAKE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_TABLE_FULL = 2'd1,
		STAT_QUEUE_FULL = 2'd2,
		STAT_NO_ACTIVE  = 2'd3
	} status_t;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam int DEV_W   = 32;
	localparam int TAG_W   = 10;
	localparam int COUNT_W = 8;

endpackage

// ===== rtl/core/pdaq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pdaq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/per_device_admission_queue_unit.sv =====
// Top level of the per-device admission queue: device table scan, semaphore
// counts and per-device waiter FIFOs. Uses pdaq_pkg, pdaq_ram, assert_macros.svh.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall   kind, device_id, requester_tag
//   out      from block out_valid / out_stall granted, wake_valid, wake_tag, status
//   cfg      to block   cfg_valid / cfg_ready cfg_data (job limit)
//
// An item is accepted in idle and is finished when its result moves into the output
// register; no new item is taken until the sequencer has returned to idle.
// The device table is walked one entry at a time through a single id comparator,
// a valid entry taking a registered RAM read and then a compare, a free one only
// the read. A wake adds the ST_WAKE state for the waiter RAM read. arst_n clears the
// valid bits, the sequencer and the job limit (to 1); no clearing pass is run.
// in_stall is high from acceptance until the result moves into the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module per_device_admission_queue_unit #(
	parameter int DEVICES = 8,
	parameter int WAITERS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [pdaq_pkg::DEV_W-1:0]    device_id,
	input  logic [pdaq_pkg::TAG_W-1:0]    requester_tag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          granted,
	output logic                          wake_valid,
	output logic [pdaq_pkg::TAG_W-1:0]    wake_tag,
	output logic [1:0]                    status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pdaq_pkg::COUNT_W-1:0]  cfg_data
);

	localparam int IW  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int PW  = $clog2(WAITERS);
	localparam int FW  = $clog2(WAITERS + 1);
	localparam int WAW = $clog2(DEVICES * WAITERS);
	localparam int EW  = pdaq_pkg::DEV_W + pdaq_pkg::COUNT_W + 2 * PW + FW;
	localparam logic [IW-1:0] LAST_IDX  = IW'(DEVICES - 1);
	localparam logic [PW-1:0] LAST_POS  = PW'(WAITERS - 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(WAITERS);

	typedef struct packed {
		logic [pdaq_pkg::DEV_W-1:0]   dev;
		logic [pdaq_pkg::COUNT_W-1:0] cnt;
		logic [PW-1:0]                head;
		logic [PW-1:0]                tail;
		logic [FW-1:0]                fill;
	} entry_t;

	pdaq_pkg::state_t  state_q, state_d;

	logic [DEVICES-1:0]               valid_q;
	logic [pdaq_pkg::COUNT_W-1:0]     job_limit_q;
	logic                             out_valid_q;

	logic                             kind_q;
	logic [pdaq_pkg::DEV_W-1:0]       dev_q;
	logic [pdaq_pkg::TAG_W-1:0]       tag_q;
	logic [IW-1:0]                    idx_q;
	logic [IW-1:0]                    eidx_q;
	logic                             free_found_q;
	logic [IW-1:0]                    free_idx_q;
	entry_t                           ent_q;

	logic                             res_granted_q, res_wake_q;
	logic [pdaq_pkg::TAG_W-1:0]       res_tag_q;
	pdaq_pkg::status_t                res_status_q;
	logic                             granted_q, wake_valid_q;
	logic [pdaq_pkg::TAG_W-1:0]       wake_tag_q;
	pdaq_pkg::status_t                status_q;

	logic                             ent_we;
	entry_t                           ent_wdata, ent_rdata;
	logic [EW-1:0]                    ent_rdata_raw;
	logic                             wt_we;
	logic [WAW-1:0]                   wt_base, wt_waddr, wt_raddr;
	logic [pdaq_pkg::TAG_W-1:0]       wt_rdata;

	logic                             in_acc, out_acc, cfg_acc, out_load;
	logic                             dev_match;
	logic [pdaq_pkg::COUNT_W-1:0]     cnt_dec;

	function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
		next_pos = (p == LAST_POS) ? '0 : p + PW'(1);
	endfunction

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_stall  = (state_q != pdaq_pkg::ST_IDLE);
	assign cfg_ready = (state_q == pdaq_pkg::ST_IDLE);
	assign out_load  = (state_q == pdaq_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	assign ent_rdata = entry_t'(ent_rdata_raw);
	assign dev_match = (ent_rdata.dev == dev_q);
	assign cnt_dec   = ent_q.cnt - pdaq_pkg::COUNT_W'(1);
	assign wt_base   = WAW'(WAITERS) * WAW'(eidx_q);

	pdaq_ram #(.WIDTH(EW), .DEPTH(DEVICES)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (eidx_q),
		.wdata (ent_wdata),
		.raddr (idx_q),
		.rdata (ent_rdata_raw)
	);

	pdaq_ram #(.WIDTH(pdaq_pkg::TAG_W), .DEPTH(DEVICES * WAITERS)) u_waiter_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (tag_q),
		.raddr (wt_raddr),
		.rdata (wt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdaq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and the datapath strobes
	always_comb begin
		state_d   = state_q;
		ent_we    = 1'b0;
		ent_wdata = ent_q;
		wt_we     = 1'b0;
		wt_waddr  = wt_base + WAW'(ent_q.tail);
		wt_raddr  = wt_base + WAW'(ent_q.head);
		case (state_q)
			pdaq_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = pdaq_pkg::ST_RD;
				end
			end
			pdaq_pkg::ST_RD: begin
				if (valid_q[idx_q]) begin
					state_d = pdaq_pkg::ST_CMP;
				end else if (idx_q == LAST_IDX) begin
					state_d = pdaq_pkg::ST_MISS;
				end
			end
			pdaq_pkg::ST_CMP: begin
				if (dev_match) begin
					state_d = pdaq_pkg::ST_EXEC;
				end else if (idx_q == LAST_IDX) begin
					state_d = pdaq_pkg::ST_MISS;
				end else begin
					state_d = pdaq_pkg::ST_RD;
				end
			end
			pdaq_pkg::ST_MISS: begin
				if (kind_q == pdaq_pkg::KIND_REQUEST && free_found_q) begin
					state_d = pdaq_pkg::ST_EXEC;
				end else begin
					state_d = pdaq_pkg::ST_DONE;
				end
			end
			pdaq_pkg::ST_EXEC: begin
				state_d = pdaq_pkg::ST_DONE;
				if (kind_q == pdaq_pkg::KIND_REQUEST) begin
					if (ent_q.cnt < job_limit_q) begin
						ent_we        = 1'b1;
						ent_wdata.cnt = ent_q.cnt + pdaq_pkg::COUNT_W'(1);
					end else if (ent_q.fill < FILL_FULL) begin
						ent_we         = 1'b1;
						wt_we          = 1'b1;
						ent_wdata.tail = next_pos(ent_q.tail);
						ent_wdata.fill = ent_q.fill + FW'(1);
					end
				end else if (ent_q.cnt != '0) begin
					ent_we        = 1'b1;
					ent_wdata.cnt = cnt_dec;
					if (cnt_dec < job_limit_q && ent_q.fill != '0) begin
						ent_wdata.head = next_pos(ent_q.head);
						ent_wdata.fill = ent_q.fill - FW'(1);
						state_d        = pdaq_pkg::ST_WAKE;
					end
				end
			end
			pdaq_pkg::ST_WAKE: begin
				state_d = pdaq_pkg::ST_DONE;
			end
			pdaq_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = pdaq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pdaq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			job_limit_q <= pdaq_pkg::COUNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				job_limit_q <= cfg_data;
			end
			if (ent_we) begin
				valid_q[eidx_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pdaq_pkg::ST_IDLE: begin
				kind_q        <= kind;
				dev_q         <= device_id;
				tag_q         <= requester_tag;
				idx_q         <= '0;
				free_found_q  <= 1'b0;
				res_granted_q <= 1'b0;
				res_wake_q    <= 1'b0;
				res_tag_q     <= '0;
				res_status_q  <= pdaq_pkg::STAT_OK;
			end
			pdaq_pkg::ST_RD: begin
				if (!valid_q[idx_q]) begin
					if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IW'(1);
					end
				end
			end
			pdaq_pkg::ST_CMP: begin
				if (dev_match) begin
					ent_q  <= ent_rdata;
					eidx_q <= idx_q;
				end else if (idx_q != LAST_IDX) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			pdaq_pkg::ST_MISS: begin
				eidx_q <= free_idx_q;
				ent_q  <= '{dev: dev_q, cnt: '0, head: '0, tail: '0, fill: '0};
				if (kind_q == pdaq_pkg::KIND_RELEASE) begin
					res_status_q <= free_found_q ? pdaq_pkg::STAT_NO_ACTIVE
					                             : pdaq_pkg::STAT_TABLE_FULL;
				end else if (!free_found_q) begin
					res_granted_q <= 1'b1;
					res_status_q  <= pdaq_pkg::STAT_TABLE_FULL;
				end
			end
			pdaq_pkg::ST_EXEC: begin
				if (kind_q == pdaq_pkg::KIND_REQUEST) begin
					if (ent_q.cnt < job_limit_q) begin
						res_granted_q <= 1'b1;
					end else if (ent_q.fill >= FILL_FULL) begin
						res_status_q <= pdaq_pkg::STAT_QUEUE_FULL;
					end
				end else if (ent_q.cnt == '0) begin
					res_status_q <= pdaq_pkg::STAT_NO_ACTIVE;
				end
			end
			pdaq_pkg::ST_WAKE: begin
				res_wake_q <= 1'b1;
				res_tag_q  <= wt_rdata;
			end
			pdaq_pkg::ST_DONE: begin
				if (out_load) begin
					granted_q    <= res_granted_q;
					wake_valid_q <= res_wake_q;
					wake_tag_q   <= res_tag_q;
					status_q     <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign granted    = granted_q;
	assign wake_valid = wake_valid_q;
	assign wake_tag   = wake_tag_q;
	assign status     = status_q;

	`ASSERT_CLK(a_accept_busy, in_acc |=> in_stall, "accepted item did not start a lookup")
	`ASSERT_CLK(a_wake_after_exec, state_q == pdaq_pkg::ST_WAKE |-> $past(state_q) == pdaq_pkg::ST_EXEC, "wake read without a release")
	`ASSERT_CLK(a_fill_bound, ent_we |-> ent_wdata.fill <= FILL_FULL, "waiter fill beyond queue depth")
	`ASSERT_CLK(a_out_from_done, $rose(out_valid) |-> $past(state_q) == pdaq_pkg::ST_DONE, "result shown before the item finished")

endmodule
